[sv/crp_pkg.sv]
// Package for the CAN payload reassembler: widths, register indexes, status
// codes, the controller state type and the structs between submodules.
// No dependencies.
package crp_pkg;

  localparam int unsigned MAX_PAYLOAD = 8;
  localparam int unsigned ID_W        = 29;
  localparam int unsigned POS_W       = 16;
  localparam int unsigned LEN_W       = 4;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned PAYLOAD_W   = MAX_PAYLOAD * BYTE_W;
  localparam int unsigned STD_ID_LSB  = 21;
  localparam int unsigned EXT_ID_LSB  = 3;
  localparam int unsigned IDE_BIT     = 2;
  localparam int unsigned CFG_AW      = 3;
  localparam int unsigned CFG_DW      = 32;

  localparam logic [POS_W-1:0] EXP_LEN_RESET = POS_W'(8);

  // Register index, taken from paddr[2].
  localparam logic REG_OWN_ID  = 1'b0;
  localparam logic REG_EXP_LEN = 1'b1;

  localparam logic [1:0] STATUS_OPEN    = 2'd0;
  localparam logic [1:0] STATUS_DONE    = 2'd1;
  localparam logic [1:0] STATUS_LEN_ERR = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } crp_state_e;

  // Commands from the controller to the byte serializer.
  typedef struct packed {
    logic load;
    logic shift;
  } crp_sh_cmd_t;

  // What the byte serializer shows to the controller.
  typedef struct packed {
    logic [BYTE_W-1:0] byte_value;
    logic              last_byte;
  } crp_sh_stat_t;

endpackage

[sv/crp_cfg.sv]
// Configuration registers of the CAN payload reassembler behind an APB-style
// port: own identifier and expected message length. Depends on crp_pkg.
module crp_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [crp_pkg::CFG_AW-1:0]    paddr,
  input  logic [crp_pkg::CFG_DW-1:0]    pwdata,
  output logic [crp_pkg::CFG_DW-1:0]    prdata,
  output logic                          pready,
  output logic [crp_pkg::ID_W-1:0]      own_id_o,
  output logic [crp_pkg::POS_W-1:0]     exp_len_o
);
  import crp_pkg::*;

  logic [ID_W-1:0]  own_id_q, own_id_d;
  logic [POS_W-1:0] exp_len_q, exp_len_d;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    own_id_d  = own_id_q;
    exp_len_d = exp_len_q;
    if (wr_en) begin
      case (paddr[2])
        REG_OWN_ID:  own_id_d  = pwdata[ID_W-1:0];
        REG_EXP_LEN: exp_len_d = pwdata[POS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_OWN_ID:  prdata = CFG_DW'(own_id_q);
      REG_EXP_LEN: prdata = CFG_DW'(exp_len_q);
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_id_q  <= '0;
      exp_len_q <= EXP_LEN_RESET;
    end else begin
      own_id_q  <= own_id_d;
      exp_len_q <= exp_len_d;
    end
  end

  assign own_id_o  = own_id_q;
  assign exp_len_o = exp_len_q;

endmodule

[sv/crp_shifter.sv]
// Byte serializer: holds the eight payload bytes of a frame in a shift
// register and hands them out low byte first, one per shift. Depends on crp_pkg.
module crp_shifter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  crp_pkg::crp_sh_cmd_t          cmd_i,
  input  logic [crp_pkg::LEN_W-1:0]     length_code_i,
  input  logic [31:0]                   payload_low_i,
  input  logic [31:0]                   payload_high_i,
  output crp_pkg::crp_sh_stat_t         stat_o
);
  import crp_pkg::*;

  logic [PAYLOAD_W-1:0] data_q, data_d;
  logic [LEN_W-1:0]     cnt_q, cnt_d;

  always_comb begin
    data_d = data_q;
    cnt_d  = cnt_q;
    if (cmd_i.load) begin
      data_d = {payload_high_i, payload_low_i};
      cnt_d  = length_code_i;
    end else if (cmd_i.shift) begin
      data_d = data_q >> BYTE_W;
      cnt_d  = cnt_q - LEN_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign stat_o.byte_value = data_q[BYTE_W-1:0];
  assign stat_o.last_byte  = (cnt_q == LEN_W'(1));

endmodule

[sv/crp_ctrl.sv]
// Controller: identifier and length checks, buffer position, and the output
// register that presents one result at a time. Depends on crp_pkg.
module crp_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          req_type_i,
  input  logic [31:0]                   id_word_i,
  input  logic [crp_pkg::LEN_W-1:0]     length_code_i,
  input  logic [crp_pkg::ID_W-1:0]      own_id_i,
  input  logic [crp_pkg::POS_W-1:0]     exp_len_i,
  output crp_pkg::crp_sh_cmd_t          sh_cmd_o,
  input  crp_pkg::crp_sh_stat_t         sh_stat_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          byte_valid_o,
  output logic [crp_pkg::BYTE_W-1:0]    byte_value_o,
  output logic [crp_pkg::POS_W-1:0]     byte_address_o,
  output logic                          id_match_o,
  output logic [1:0]                    status_o,
  output logic                          last_o
);
  import crp_pkg::*;

  crp_state_e        state_q, state_d;
  logic              match_q, match_d;
  logic              len_err_q, len_err_d;
  logic              empty_q, empty_d;
  logic [POS_W-1:0]  pos_q, pos_d;

  logic              out_valid_q, out_valid_d;
  logic              byte_valid_q, byte_valid_d;
  logic [BYTE_W-1:0] byte_value_q, byte_value_d;
  logic [POS_W-1:0]  byte_address_q, byte_address_d;
  logic              id_match_q, id_match_d;
  logic [1:0]        status_q, status_d;
  logic              last_q, last_d;

  logic              accept;
  logic              load_en;
  logic              emit;
  logic              byte_path;
  logic [ID_W-1:0]   frame_id;
  logic [POS_W-1:0]  pos_inc;
  logic              done;

  logic              res_byte_valid;
  logic              res_id_match;
  logic [1:0]        res_status;
  logic              res_last;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i & in_ready_o;
  // The output register takes a new result when it is empty or being drained.
  assign load_en    = ~out_valid_q | out_ready_i;
  assign emit       = (state_q == ST_EMIT) & load_en;
  assign byte_path  = match_q & ~len_err_q & ~empty_q;

  assign frame_id = id_word_i[IDE_BIT] ? id_word_i[31:EXT_ID_LSB]
                                       : ID_W'(id_word_i[31:STD_ID_LSB]);

  assign pos_inc = pos_q + POS_W'(1);
  assign done    = (pos_inc >= exp_len_i);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && !req_type_i) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit && res_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Result of the current step and serializer commands.
  always_comb begin
    res_byte_valid = 1'b0;
    res_id_match   = match_q;
    res_status     = STATUS_OPEN;
    res_last       = 1'b1;
    sh_cmd_o.load  = 1'b0;
    sh_cmd_o.shift = 1'b0;
    case (state_q)
      ST_IDLE: begin
        sh_cmd_o.load = accept & ~req_type_i;
      end
      ST_EMIT: begin
        if (match_q && len_err_q) begin
          res_status = STATUS_LEN_ERR;
        end else if (byte_path) begin
          res_byte_valid = 1'b1;
          sh_cmd_o.shift = load_en;
          if (done) begin
            res_status = STATUS_DONE;
          end else begin
            res_last = sh_stat_i.last_byte;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    match_d   = match_q;
    len_err_d = len_err_q;
    empty_d   = empty_q;
    pos_d     = pos_q;
    if (accept) begin
      if (req_type_i) begin
        pos_d = '0;
      end else begin
        match_d   = (frame_id == own_id_i);
        len_err_d = (length_code_i > LEN_W'(MAX_PAYLOAD));
        empty_d   = (length_code_i == '0);
      end
    end else if (emit && byte_path) begin
      pos_d = done ? '0 : pos_inc;
    end
  end

  always_comb begin
    out_valid_d    = out_valid_q;
    byte_valid_d   = byte_valid_q;
    byte_value_d   = byte_value_q;
    byte_address_d = byte_address_q;
    id_match_d     = id_match_q;
    status_d       = status_q;
    last_d         = last_q;
    if (emit) begin
      out_valid_d    = 1'b1;
      byte_valid_d   = res_byte_valid;
      byte_value_d   = res_byte_valid ? sh_stat_i.byte_value : '0;
      byte_address_d = res_byte_valid ? pos_q : '0;
      id_match_d     = res_id_match;
      status_d       = res_status;
      last_d         = res_last;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    match_q        <= match_d;
    len_err_q      <= len_err_d;
    empty_q        <= empty_d;
    byte_valid_q   <= byte_valid_d;
    byte_value_q   <= byte_value_d;
    byte_address_q <= byte_address_d;
    id_match_q     <= id_match_d;
    status_q       <= status_d;
    last_q         <= last_d;
  end

  assign out_valid_o    = out_valid_q;
  assign byte_valid_o   = byte_valid_q;
  assign byte_value_o   = byte_value_q;
  assign byte_address_o = byte_address_q;
  assign id_match_o     = id_match_q;
  assign status_o       = status_q;
  assign last_o         = last_q;

endmodule

[sv/can_payload_reassembler.sv]
// Top level of the CAN payload reassembler: configuration registers, byte
// serializer and controller. Depends on crp_pkg, crp_cfg, crp_shifter, crp_ctrl.
//
//   channel  direction  handshake                   contents
//   in       request    in_valid_i / in_ready_o     req_type, id_word, length_code, payload
//   out      result     out_valid_o / out_ready_i   byte_valid .. last
//   cfg      APB write  psel, penable, pwrite       own_identifier, expected_length
//
// A frame yields one result per cycle while the output is not stalled, n results
// in all (n from 1 to 8), set by the byte serializer that shifts out one
// payload byte per result.
// A position reset request gives no result.
// A new request is taken while the last result still waits in the output register.
// A stalled output holds the controller; reset clears the position and
// restores expected_length to 8.
module can_payload_reassembler (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [crp_pkg::CFG_AW-1:0]    paddr,
  input  logic [crp_pkg::CFG_DW-1:0]    pwdata,
  output logic [crp_pkg::CFG_DW-1:0]    prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          req_type_i,
  input  logic [31:0]                   id_word_i,
  input  logic [3:0]                    length_code_i,
  input  logic [31:0]                   payload_low_i,
  input  logic [31:0]                   payload_high_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          byte_valid_o,
  output logic [7:0]                    byte_value_o,
  output logic [15:0]                   byte_address_o,
  output logic                          id_match_o,
  output logic [1:0]                    status_o,
  output logic                          last_o
);
  import crp_pkg::*;

  logic [ID_W-1:0]  own_id;
  logic [POS_W-1:0] exp_len;
  crp_sh_cmd_t      sh_cmd;
  crp_sh_stat_t     sh_stat;

  crp_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .own_id_o  (own_id),
    .exp_len_o (exp_len)
  );

  crp_shifter u_shifter (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (sh_cmd),
    .length_code_i  (length_code_i),
    .payload_low_i  (payload_low_i),
    .payload_high_i (payload_high_i),
    .stat_o         (sh_stat)
  );

  crp_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .req_type_i     (req_type_i),
    .id_word_i      (id_word_i),
    .length_code_i  (length_code_i),
    .own_id_i       (own_id),
    .exp_len_i      (exp_len),
    .sh_cmd_o       (sh_cmd),
    .sh_stat_i      (sh_stat),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .byte_valid_o   (byte_valid_o),
    .byte_value_o   (byte_value_o),
    .byte_address_o (byte_address_o),
    .id_match_o     (id_match_o),
    .status_o       (status_o),
    .last_o         (last_o)
  );

endmodule

[sv/crp_checker.sv]
// Port-level checker for the CAN payload reassembler, bound to the top level.
// Depends on crp_pkg and can_payload_reassembler.
module crp_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic                          byte_valid_o,
  input logic [7:0]                    byte_value_o,
  input logic [15:0]                   byte_address_o,
  input logic                          id_match_o,
  input logic [1:0]                    status_o,
  input logic                          last_o
);
  import crp_pkg::*;

  // A stalled result holds its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(byte_value_o)
      && $stable(byte_address_o) && $stable(status_o) && $stable(last_o))
    else $error("result changed while stalled");

  // A rejected frame gives a single result that carries no byte.
  a_mismatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !id_match_o |-> !byte_valid_o && last_o && status_o == STATUS_OPEN)
    else $error("identifier mismatch result malformed");

  // A length error is a matched frame with no byte and ends the request.
  a_len_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STATUS_LEN_ERR |-> id_match_o && !byte_valid_o && last_o)
    else $error("length error result malformed");

  // Completion always comes with a stored byte and ends the request.
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STATUS_DONE |-> byte_valid_o && last_o && id_match_o)
    else $error("completion result malformed");

endmodule

bind can_payload_reassembler crp_checker u_crp_checker (.*);
